// ----- design/ttkm_pkg.sv -----
// Shared types, constants and helpers for the tournament tree k-way merge unit.
// No dependencies.
`default_nettype none
package ttkm_pkg;

    localparam int MAX_LISTS  = 8;
    localparam int MAX_LENGTH = 256;

    localparam int LIST_W  = $clog2(MAX_LISTS);
    localparam int POS_W   = $clog2(MAX_LENGTH);
    localparam int ADDR_W  = LIST_W + POS_W;
    localparam int HEAD_W  = 9;
    localparam int NL_W    = 4;
    localparam int LEN_W   = 9;
    localparam int VAL_W   = 32;
    localparam int ENTRY_W = VAL_W + 1;    // tournament entry: {full, value}

    // configuration register indexes
    localparam logic CFG_NUM_LISTS   = 1'b0;
    localparam logic CFG_LIST_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_POP    = 2'd1,
        OP_REPORT = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_ROUND
    } t_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [VAL_W-1:0]  data;
    } t_wr_req;

    function automatic logic less_signed(input logic [VAL_W-1:0] a,
                                         input logic [VAL_W-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

endpackage
`default_nettype wire

// ----- design/ttkm_store.sv -----
// Element store: single-port-write, registered-read synchronous memory.
// Depends on ttkm_pkg.
`default_nettype none
module ttkm_store (
    input  wire logic                       i_clk,
    input  wire ttkm_pkg::t_wr_req          i_wr,
    input  wire logic [ttkm_pkg::ADDR_W-1:0] i_rd_addr,
    output logic      [ttkm_pkg::VAL_W-1:0]  o_rd_data
);

    logic [ttkm_pkg::VAL_W-1:0] mem [ttkm_pkg::MAX_LISTS * ttkm_pkg::MAX_LENGTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        o_rd_data <= mem[i_rd_addr];
    end

endmodule
`default_nettype wire

// ----- design/tournament_tree_kway_merge_unit.sv -----
// Top level of the tournament tree k-way merge unit.
// Depends on ttkm_pkg and ttkm_store.
//
// Use:
//   Requests enter on start/busy: a request is taken at a clock edge with
//   start high and busy low. i_op selects load element (0), pop minimum
//   head (1) or report (2); op 3 is dropped.
//   A load writes the element store at the taking edge; busy stays low.
//   Pop and report walk the list heads, one element store read per cycle
//   (registered read) over the nl lists in use; pop then bumps the
//   winning list's head.
//   A report emits each head (level 0) through the result registers as
//   its read returns, then plays the tournament one pair per cycle
//   through one comparator, emitting each winner (levels 1..3, o_last
//   on the final one). Results come as one-cycle o_res_valid strobes;
//   the receiver cannot stall, so no back-pressure exists. The last
//   result of a report shows in the first cycle with busy low.
//   Config writes use i_cfg_valid/o_cfg_ready and are taken only while idle.
//   Reset (synchronous, active low) clears the heads and sets 8 lists of
//   256 elements; the element store is not cleared.
`default_nettype none
module tournament_tree_kway_merge_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request channel
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    i_op,
    input  wire logic [ttkm_pkg::LIST_W-1:0]   i_list_select,
    input  wire logic [ttkm_pkg::POS_W-1:0]    i_position,
    input  wire logic signed [ttkm_pkg::VAL_W-1:0] i_value,
    // result strobe
    output logic                               o_res_valid,
    output logic signed [ttkm_pkg::VAL_W-1:0]  o_value_res,
    output logic                               o_is_empty,
    output logic [1:0]                         o_level,
    output logic                               o_last,
    // configuration channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic                          i_cfg_index,
    input  wire logic [ttkm_pkg::LEN_W-1:0]    i_cfg_data
);

    ttkm_pkg::t_state r_state, n_state;

    // configuration
    logic [ttkm_pkg::NL_W-1:0]  r_num_lists;
    logic [ttkm_pkg::LEN_W-1:0] r_list_length;
    logic [ttkm_pkg::NL_W-1:0]  nl;
    logic [ttkm_pkg::LEN_W-1:0] len;

    // head scan
    logic [ttkm_pkg::LIST_W-1:0] r_idx;
    logic                        r_is_report;
    logic                        r_rd_valid;
    logic                        r_rd_full;
    logic [ttkm_pkg::LIST_W-1:0] r_rd_idx;
    logic [ttkm_pkg::HEAD_W-1:0] r_head [ttkm_pkg::MAX_LISTS];
    logic                        r_found;
    logic [ttkm_pkg::LIST_W-1:0] r_best;
    logic [ttkm_pkg::VAL_W-1:0]  r_best_val;

    // tournament
    logic [ttkm_pkg::ENTRY_W-1:0] r_cur [ttkm_pkg::MAX_LISTS];
    logic [ttkm_pkg::ENTRY_W-1:0] r_nxt [ttkm_pkg::MAX_LISTS];
    logic [ttkm_pkg::NL_W-1:0]    r_cnt;
    logic [ttkm_pkg::LIST_W-1:0]  r_n;
    logic [1:0]                   r_level;

    // result registers
    logic                        r_res_valid;
    logic [ttkm_pkg::VAL_W-1:0]  r_res_value;
    logic                        r_res_empty;
    logic [1:0]                  r_res_level;
    logic                        r_res_last;

    logic                         accept;
    logic                         issue_last;
    logic [ttkm_pkg::HEAD_W-1:0]  hp_sel;
    logic                         rd_full_now;
    ttkm_pkg::t_wr_req            wr_req;
    logic [ttkm_pkg::ADDR_W-1:0]  rd_addr;
    logic [ttkm_pkg::VAL_W-1:0]   rd_data;
    logic                         take;
    logic                         n_found;
    logic [ttkm_pkg::LIST_W-1:0]  n_best;
    logic [ttkm_pkg::VAL_W-1:0]   n_best_val;
    logic [ttkm_pkg::ENTRY_W-1:0] pa, pb, pw;
    logic [ttkm_pkg::NL_W-1:0]    outcnt;
    logic                         round_end;
    logic                         tour_done;
    logic                         head_emit;
    logic                         round_emit;

    // clamped configuration
    always_comb begin
        if (r_num_lists == '0) begin
            nl = ttkm_pkg::NL_W'(1);
        end else if (r_num_lists > ttkm_pkg::NL_W'(ttkm_pkg::MAX_LISTS)) begin
            nl = ttkm_pkg::NL_W'(ttkm_pkg::MAX_LISTS);
        end else begin
            nl = r_num_lists;
        end
        if (r_list_length > ttkm_pkg::LEN_W'(ttkm_pkg::MAX_LENGTH)) begin
            len = ttkm_pkg::LEN_W'(ttkm_pkg::MAX_LENGTH);
        end else begin
            len = r_list_length;
        end
    end

    assign busy        = (r_state != ttkm_pkg::ST_IDLE);
    assign o_cfg_ready = ~busy;
    assign accept      = start & ~busy;

    assign issue_last = ({1'b0, r_idx} == (nl - ttkm_pkg::NL_W'(1)));
    // winners of the current round once its last pair is played
    assign outcnt     = {1'b0, r_n} + ttkm_pkg::NL_W'(1);
    assign round_end  = (r_cnt <= ttkm_pkg::NL_W'(2));
    assign tour_done  = round_end && (r_n == '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ttkm_pkg::ST_IDLE: begin
                if (accept && (i_op == ttkm_pkg::OP_POP || i_op == ttkm_pkg::OP_REPORT)) begin
                    n_state = ttkm_pkg::ST_SCAN;
                end
            end
            ttkm_pkg::ST_SCAN: begin
                if (issue_last) begin
                    n_state = ttkm_pkg::ST_DRAIN;
                end
            end
            ttkm_pkg::ST_DRAIN: begin
                n_state = r_is_report ? ttkm_pkg::ST_ROUND : ttkm_pkg::ST_IDLE;
            end
            ttkm_pkg::ST_ROUND: begin
                if (tour_done) begin
                    n_state = ttkm_pkg::ST_IDLE;
                end
            end
            default: n_state = ttkm_pkg::ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        hp_sel      = r_head[r_idx];
        rd_full_now = (hp_sel < len);
        rd_addr     = {r_idx, hp_sel[ttkm_pkg::POS_W-1:0]};

        wr_req.we   = accept && (i_op == ttkm_pkg::OP_LOAD);
        wr_req.addr = {i_list_select, i_position};
        wr_req.data = i_value;

        // pop: strict less keeps the lowest list on a tie
        take = r_rd_valid && r_rd_full
               && (!r_found || ttkm_pkg::less_signed(rd_data, r_best_val));
        n_found    = r_found | take;
        n_best     = take ? r_rd_idx : r_best;
        n_best_val = take ? rd_data  : r_best_val;

        // one tournament pair; an odd tail meets an empty partner
        pa = r_cur[0];
        pb = (r_cnt >= ttkm_pkg::NL_W'(2)) ? r_cur[1] : '0;
        if (pa[ttkm_pkg::ENTRY_W-1] && pb[ttkm_pkg::ENTRY_W-1]) begin
            pw = ttkm_pkg::less_signed(pa[ttkm_pkg::VAL_W-1:0], pb[ttkm_pkg::VAL_W-1:0])
                 ? pa : pb;
        end else if (pa[ttkm_pkg::ENTRY_W-1]) begin
            pw = pa;
        end else begin
            pw = pb;
        end

        head_emit  = r_rd_valid && r_is_report;
        round_emit = (r_state == ttkm_pkg::ST_ROUND);
    end

    ttkm_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr_req),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ttkm_pkg::ST_IDLE;
            r_num_lists   <= ttkm_pkg::NL_W'(ttkm_pkg::MAX_LISTS);
            r_list_length <= ttkm_pkg::LEN_W'(ttkm_pkg::MAX_LENGTH);
            r_rd_valid    <= 1'b0;
            r_found       <= 1'b0;
            r_res_valid   <= 1'b0;
            for (int k = 0; k < ttkm_pkg::MAX_LISTS; k++) begin
                r_head[k] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == ttkm_pkg::CFG_NUM_LISTS) begin
                    r_num_lists <= i_cfg_data[ttkm_pkg::NL_W-1:0];
                end else begin
                    r_list_length <= i_cfg_data;
                end
            end

            if (r_state == ttkm_pkg::ST_IDLE && accept) begin
                r_idx       <= '0;
                r_is_report <= (i_op == ttkm_pkg::OP_REPORT);
                r_found     <= 1'b0;
            end

            // one head read issued per scan cycle
            r_rd_valid <= (r_state == ttkm_pkg::ST_SCAN);
            if (r_state == ttkm_pkg::ST_SCAN) begin
                r_idx     <= r_idx + ttkm_pkg::LIST_W'(1);
                r_rd_full <= rd_full_now;
                r_rd_idx  <= r_idx;
            end

            if (r_rd_valid) begin
                r_found    <= n_found;
                r_best     <= n_best;
                r_best_val <= n_best_val;
                if (r_is_report) begin
                    r_cur[r_rd_idx] <= {r_rd_full,
                                        r_rd_full ? rd_data : {ttkm_pkg::VAL_W{1'b0}}};
                end
            end

            if (r_state == ttkm_pkg::ST_DRAIN) begin
                if (!r_is_report && n_found) begin
                    r_head[n_best] <= r_head[n_best] + ttkm_pkg::HEAD_W'(1);
                end
                r_cnt   <= nl;
                r_n     <= '0;
                r_level <= 2'd1;
            end

            if (r_state == ttkm_pkg::ST_ROUND) begin
                r_nxt[r_n] <= pw;
                if (round_end && !tour_done) begin
                    // next round takes this round's winners, newest in place
                    for (int k = 0; k < ttkm_pkg::MAX_LISTS; k++) begin
                        r_cur[k] <= (ttkm_pkg::LIST_W'(k) == r_n) ? pw : r_nxt[k];
                    end
                    r_cnt   <= outcnt;
                    r_n     <= '0;
                    r_level <= r_level + 2'd1;
                end else begin
                    r_n <= r_n + ttkm_pkg::LIST_W'(1);
                    for (int k = 0; k < ttkm_pkg::MAX_LISTS - 2; k++) begin
                        r_cur[k] <= r_cur[k+2];
                    end
                    r_cnt <= round_end ? '0 : r_cnt - ttkm_pkg::NL_W'(2);
                end
            end

            r_res_valid <= head_emit | round_emit;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (round_emit) begin
            r_res_value <= pw[ttkm_pkg::ENTRY_W-1] ? pw[ttkm_pkg::VAL_W-1:0] : '0;
            r_res_empty <= ~pw[ttkm_pkg::ENTRY_W-1];
            r_res_level <= r_level;
            r_res_last  <= tour_done;
        end else begin
            r_res_value <= r_rd_full ? rd_data : '0;
            r_res_empty <= ~r_rd_full;
            r_res_level <= 2'd0;
            r_res_last  <= 1'b0;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_value_res = r_res_value;
    assign o_is_empty  = r_res_empty;
    assign o_level     = r_res_level;
    assign o_last      = r_res_last;

endmodule
`default_nettype wire
